>>> rtl/core/ttrc_pkg.sv
package ttrc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned TermW = 16;
  localparam int unsigned ProdW = 25;

  localparam logic [TermW-1:0] StartOffset = 16'd7;
  localparam logic [TermW-1:0] TermMod     = 16'hFFFF;
  localparam logic [TermW-1:0] PrevInit    = 16'd1;

  // Reduces a 25-bit value modulo 2^16 - 1 with one end-around fold and one
  // conditional subtract.
  function automatic logic [TermW-1:0] term_mod(input logic [ProdW-1:0] x);
    logic [TermW:0] fold;
    logic [TermW:0] red;
    fold = {8'd0, x[ProdW-1:TermW]} + {1'b0, x[TermW-1:0]};
    red  = (fold >= {1'b0, TermMod}) ? fold - {1'b0, TermMod} : fold;
    return red[TermW-1:0];
  endfunction

endpackage

>>> rtl/core/three_term_recurrence_checksum_unit.sv
// Channel   Dir  Width  Contents
// s_axis    in   8+1    tdata: data_byte; tlast: last_byte
// m_axis    out  16     tdata: checksum
//
// Every accepted byte is folded into the recurrence in the cycle it is taken,
// so one byte per clock is sustained while the output buffer has room; the
// combinational term update (two small multipliers and a mod 2^16-1
// reduction) sets that figure. A checksum is registered as its last byte is taken.
// Reset clears the recurrence and the output buffer; the first byte after reset
// opens a new message. A two-entry output buffer lets input keep flowing while
// one checksum waits for the sink; input stalls only when both entries are full.
module three_term_recurrence_checksum_unit
  import ttrc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [ByteW-1:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic             s_axis_tlast_i,   // last_byte
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [TermW-1:0] m_axis_tdata_o    // [15:0] checksum
);

  // Recurrence state.
  logic [TermW-1:0] prev_q, prev_d;
  logic [TermW-1:0] cur_q, cur_d;
  logic [ByteW-1:0] pos_q, pos_d;
  logic             in_msg_q, in_msg_d;

  // Output register and its skid entry.
  logic             out_valid_q, skid_valid_q;
  logic [TermW-1:0] out_data_q, skid_data_q;

  logic             in_fire, out_fire, push;
  logic [ByteW-1:0] coef_a, coef_b;
  logic [ByteW:0]   mult_a;
  logic [ProdW-1:0] plus, minus, mag;
  logic             no_borrow;
  logic [TermW-1:0] red, next_term;

  assign s_axis_tready_o = ~skid_valid_q;
  assign in_fire  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_fire = out_valid_q & m_axis_tready_i;
  assign push     = in_fire & s_axis_tlast_i;

  // Coefficients: 17*i and 31*i, both taken mod 256 by truncation.
  assign coef_a = pos_q + {pos_q[3:0], 4'd0};
  assign coef_b = {pos_q[2:0], 5'd0} - pos_q;

  assign mult_a = {1'b0, s_axis_tdata_i} + {1'b0, coef_a};
  assign plus   = ProdW'(mult_a) * ProdW'(cur_q);
  assign minus  = ProdW'(coef_b) * ProdW'(prev_q);

  // The difference is formed as a magnitude. A negative difference wraps as a
  // 64-bit unsigned value, and since 2^64 is 1 mod 2^16-1 the term becomes
  // 1 minus the reduced deficit.
  assign no_borrow = plus >= minus;
  assign mag       = no_borrow ? plus - minus : minus - plus;
  assign red       = term_mod(mag);

  always_comb begin
    if (no_borrow) begin
      next_term = red;
    end else if (red == '0) begin
      next_term = PrevInit;
    end else if (red == PrevInit) begin
      next_term = '0;
    end else begin
      next_term = TermW'(0) - red;
    end
  end

  always_comb begin
    prev_d   = prev_q;
    cur_d    = cur_q;
    pos_d    = pos_q;
    in_msg_d = in_msg_q;
    if (in_fire) begin
      if (!in_msg_q) begin
        // First byte of a message opens the recurrence.
        prev_d = PrevInit;
        cur_d  = {8'd0, s_axis_tdata_i} + StartOffset;
        pos_d  = ByteW'(1);
      end else begin
        prev_d = cur_q;
        cur_d  = next_term;
        pos_d  = pos_q + ByteW'(1);
      end
      in_msg_d = ~s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= PrevInit;
      cur_q    <= '0;
      pos_q    <= '0;
      in_msg_q <= 1'b0;
    end else begin
      prev_q   <= prev_d;
      cur_q    <= cur_d;
      pos_q    <= pos_d;
      in_msg_q <= in_msg_d;
    end
  end

  // The finished checksum is cur_d of the cycle that takes the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
        if (push) begin
          skid_data_q <= cur_d;
        end
      end else if (push) begin
        out_data_q <= cur_d;
      end
    end else if (push) begin
      skid_data_q <= cur_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
